[rtl/bmc_pkg.sv]
package bmc_pkg;

  typedef struct packed {
    logic [11:0] x_position;
    logic [11:0] box_width;
    logic [23:0] box_area;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] lateral_motion;
    logic [1:0] depth_motion;
  } out_beat_t;

  localparam logic [1:0] MOVE_NONE  = 2'd0;
  localparam logic [1:0] MOVE_LEFT  = 2'd1;
  localparam logic [1:0] MOVE_RIGHT = 2'd2;
  localparam logic [1:0] MOVE_FRONT = 2'd1;
  localparam logic [1:0] MOVE_BACK  = 2'd2;

endpackage

[rtl/bmc_cell.sv]
module bmc_cell #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         shift_en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/bmc_cdiv.sv]
module bmc_cdiv #(
  parameter int IN_W  = 16,
  parameter int DIV   = 6,
  parameter int OUT_W = 12
) (
  input  logic             clk,
  input  logic             load_en,
  input  logic [IN_W-1:0]  num,
  output logic [OUT_W-1:0] quo
);

  // The quotient is the product with a rounded-up reciprocal, exact over the
  // whole input range because the shift covers the divisor's bit count.
  localparam int SH  = $clog2(DIV);
  localparam int K   = IN_W + SH;
  localparam int R_W = IN_W + 2;
  localparam int P_W = IN_W + R_W;
  localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [R_W-1:0] RECIP = RECIP64[R_W-1:0];

  logic [P_W-1:0]   prod;
  logic [OUT_W-1:0] quo_r;
  logic [OUT_W-1:0] quo_nxt;

  assign prod = P_W'(num) * P_W'(RECIP);

  always_comb begin
    quo_nxt = quo_r;
    if (load_en) begin
      quo_nxt = prod[K +: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

[rtl/box_motion_classifier_core.sv]
// Two register stages: an accepted beat is held in stage one and moves on to
// the output register once out_stall lets that register take a new result.
// Throughput: one beat per cycle unless stalled; history cells shift and running
// window sums update in the accept cycle; reciprocal multipliers take one stage.
// Reset (synchronous, active low) clears the history cells, the window sums,
// the frame counter and all valid flags.
module box_motion_classifier_core #(
  parameter int X_WINDOW    = 6,
  parameter int AREA_WINDOW = 8,
  parameter int AREA_DELAY  = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmc_pkg::out_beat_t  out_data
);

  localparam int AREA_DEPTH = AREA_WINDOW + AREA_DELAY;
  localparam int SEEN_MAX   = (AREA_DEPTH > X_WINDOW) ? AREA_DEPTH : X_WINDOW;
  localparam int SEEN_W     = $clog2(SEEN_MAX + 1);
  localparam int XSUM_W     = 12 + $clog2(X_WINDOW);
  localparam int ASUM_W     = 24 + $clog2(AREA_WINDOW);
  localparam logic [XSUM_W-1:0] XSUM_MAX = XSUM_W'(X_WINDOW * 4095);

  logic in_accept;
  logic s1_ready;
  logic out_ready;

  // History cells, newest first.
  logic [23:0] xw_q   [X_WINDOW];
  logic [23:0] area_q [AREA_DEPTH];
  logic [23:0] a_enter;

  genvar gi;
  generate
    for (gi = 0; gi < X_WINDOW; gi++) begin : g_xw
      logic [23:0] d_in;
      if (gi == 0) begin : g_head
        assign d_in = {in_data.x_position, in_data.box_width};
      end else begin : g_link
        assign d_in = xw_q[gi-1];
      end
      bmc_cell #(.W(24)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_accept),
        .d        (d_in),
        .q        (xw_q[gi])
      );
    end

    for (gi = 0; gi < AREA_DEPTH; gi++) begin : g_area
      logic [23:0] d_in;
      if (gi == 0) begin : g_head
        assign d_in = in_data.box_area;
      end else begin : g_link
        assign d_in = area_q[gi-1];
      end
      bmc_cell #(.W(24)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_accept),
        .d        (d_in),
        .q        (area_q[gi])
      );
    end

    if (AREA_DELAY == 0) begin : g_enter_new
      assign a_enter = in_data.box_area;
    end else begin : g_enter_old
      assign a_enter = area_q[AREA_DELAY-1];
    end
  endgenerate

  // Running window sums and frame counter.
  logic [XSUM_W-1:0] xs_r, xs_nxt;
  logic [XSUM_W-1:0] ws_r, ws_nxt;
  logic [ASUM_W-1:0] as_r, as_nxt;
  logic [SEEN_W-1:0] frames_r, frames_nxt;

  always_comb begin
    xs_nxt     = xs_r;
    ws_nxt     = ws_r;
    as_nxt     = as_r;
    frames_nxt = frames_r;
    if (in_accept) begin
      xs_nxt = xs_r + XSUM_W'(in_data.x_position) - XSUM_W'(xw_q[X_WINDOW-1][23:12]);
      ws_nxt = ws_r + XSUM_W'(in_data.box_width) - XSUM_W'(xw_q[X_WINDOW-1][11:0]);
      as_nxt = as_r + ASUM_W'(a_enter) - ASUM_W'(area_q[AREA_DEPTH-1]);
      if (frames_r < SEEN_W'(SEEN_MAX)) begin
        frames_nxt = frames_r + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_r     <= '0;
      ws_r     <= '0;
      as_r     <= '0;
      frames_r <= '0;
    end else begin
      xs_r     <= xs_nxt;
      ws_r     <= ws_nxt;
      as_r     <= as_nxt;
      frames_r <= frames_nxt;
    end
  end

  // Stage one: averages and margins of the earlier frames.
  logic [11:0] xavg;
  logic [9:0]  xmar;
  logic [23:0] aavg;
  logic [21:0] amar;

  bmc_cdiv #(.IN_W(XSUM_W), .DIV(X_WINDOW), .OUT_W(12)) u_xavg (
    .clk (clk), .load_en (in_accept), .num (xs_r), .quo (xavg)
  );
  bmc_cdiv #(.IN_W(XSUM_W), .DIV(8 * X_WINDOW), .OUT_W(10)) u_xmar (
    .clk (clk), .load_en (in_accept), .num (ws_r), .quo (xmar)
  );
  bmc_cdiv #(.IN_W(ASUM_W), .DIV(AREA_WINDOW), .OUT_W(24)) u_aavg (
    .clk (clk), .load_en (in_accept), .num (as_r), .quo (aavg)
  );
  bmc_cdiv #(.IN_W(ASUM_W), .DIV(12 * AREA_WINDOW), .OUT_W(22)) u_amar (
    .clk (clk), .load_en (in_accept), .num (as_r), .quo (amar)
  );

  logic        s1_v_r, s1_v_nxt;
  logic [11:0] s1_x_r;
  logic [23:0] s1_a_r;
  logic        s1_lat_ok_r;
  logic        s1_dep_ok_r;
  logic        out_valid_r, out_valid_nxt;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_v_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r      <= in_data.x_position;
      s1_a_r      <= in_data.box_area;
      s1_lat_ok_r <= (frames_r >= SEEN_W'(X_WINDOW));
      s1_dep_ok_r <= (frames_r >= SEEN_W'(AREA_DEPTH));
    end
  end

  // Stage two: classification into the output register.
  bmc_pkg::out_beat_t out_data_r, out_data_nxt;
  logic [1:0]         lat_code;
  logic [1:0]         dep_code;

  always_comb begin
    lat_code = bmc_pkg::MOVE_NONE;
    dep_code = bmc_pkg::MOVE_NONE;
    if (s1_lat_ok_r) begin
      if (s1_x_r > xavg && (s1_x_r - xavg) > {2'b00, xmar}) begin
        lat_code = bmc_pkg::MOVE_RIGHT;
      end else if (s1_x_r < xavg && (xavg - s1_x_r) > {2'b00, xmar}) begin
        lat_code = bmc_pkg::MOVE_LEFT;
      end
    end
    if (s1_dep_ok_r) begin
      if (s1_a_r > aavg && (s1_a_r - aavg) > {2'b00, amar}) begin
        dep_code = bmc_pkg::MOVE_FRONT;
      end else if (s1_a_r < aavg && (aavg - s1_a_r) > {2'b00, amar}) begin
        dep_code = bmc_pkg::MOVE_BACK;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = s1_v_r;
      if (s1_v_r) begin
        out_data_nxt.lateral_motion = lat_code;
        out_data_nxt.depth_motion   = dep_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_frames_bound : assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= SEEN_W'(SEEN_MAX))
    else $error("frame counter passed its saturation value");

  a_xsum_bound : assert property (@(posedge clk) disable iff (!rst_n)
    xs_r <= XSUM_MAX && ws_r <= XSUM_MAX)
    else $error("lateral window sum out of range");

  a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_v_r)
    else $error("accepted beat lost before the classify stage");

  a_short_lateral : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_ready && !s1_lat_ok_r) |=>
      (out_data_r.lateral_motion == bmc_pkg::MOVE_NONE))
    else $error("lateral motion reported with short history");

endmodule
